// ----- rtl/iarl_pkg.sv -----
// iarl_pkg: shared types and constants for the indexed array list
// holds capacity and widths, word type, opcode and status codes, cell select and fsm state codes and beat structs
// no dependencies
`timescale 1ns / 1ps

package iarl_pkg;

   localparam int CAPACITY = 16;
   localparam int CAP_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int INDEX_W  = 5;
   localparam int COUNT_W  = 5;
   localparam int CMP_W    = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

   typedef logic signed [31:0] word_type;

   typedef enum logic [3:0] {
      FN_GET       = 4'd0,
      FN_INS_AT    = 4'd1,
      FN_DEL_AT    = 4'd2,
      FN_INS_FIRST = 4'd3,
      FN_INS_LAST  = 4'd4,
      FN_DEL_FIRST = 4'd5,
      FN_DEL_LAST  = 4'd6,
      FN_WALK_FWD  = 4'd7,
      FN_WALK_BWD  = 4'd8
   } func_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2,
      ST_EMPTY = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      SEL_HOLD,
      SEL_LEFT,
      SEL_RIGHT,
      SEL_LOAD
   } sel_type;

   typedef enum logic {
      FSM_IDLE,
      FSM_WALK
   } fsm_type;

   typedef struct packed {
      logic [3:0]         func;
      logic [INDEX_W-1:0] index;
      word_type           value;
   } req_type;

   typedef struct packed {
      word_type           read_value;
      logic [1:0]         status;
      logic [COUNT_W-1:0] count;
      logic               last;
   } rsp_type;

endpackage

// ----- rtl/iarl_cell.sv -----
// iarl_cell: one storage cell of the list chain
// holds one element and loads from its neighbours or the new word
// depends on iarl_pkg
`timescale 1ns / 1ps

module iarl_cell
   import iarl_pkg::*;
(
   input  logic     clock,
   input  sel_type  sel,
   input  word_type left_d,
   input  word_type right_d,
   input  word_type load_d,
   output word_type q
);

   word_type q_ff;
   word_type q_in;

   always_comb begin
      case (sel)
         SEL_LEFT:  q_in = left_d;
         SEL_RIGHT: q_in = right_d;
         SEL_LOAD:  q_in = load_d;
         default:   q_in = q_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
   end

   assign q = q_ff;

endmodule

// ----- rtl/indexed_array_list.sv -----
// indexed_array_list: ordered list of signed words held in a chain of cells
// top level with control, walk sequencer and response register
// depends on iarl_pkg and iarl_cell
`timescale 1ns / 1ps

// Usage
// req channel (req_valid, req_ready, req_data) carries one operation per beat:
// get, insert or delete at an index, the front or the back, or a walk.
// rsp channel (rsp_valid, rsp_ready, rsp_data) returns one beat per operation,
// or one beat per element for a walk, with last set on the final beat.
// Get, insert and delete are done in the accepting cycle: every cell loads
// from itself, its left or right neighbour or the new word, so the whole
// tail shifts at once. The response is registered and appears in the cycle
// after acceptance; one operation can be taken every cycle while rsp_ready
// stays high. During a walk the sequencer steps one element per cycle, while
// rsp_ready stays high, through the read mux of the chain, and req_ready is
// low until its last beat has been loaded.
// A single response register sits between the channels; while rsp_ready is
// low the register holds its beat and no new request or walk beat is taken.
// Synchronous reset empties the list and the response register; element
// contents are not cleared and are never read before being written.

module indexed_array_list
   import iarl_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   fsm_type            fsm_ff, fsm_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CAP_W-1:0]   walk_idx_ff, walk_idx_in;
   logic [CNT_W-1:0]   walk_left_ff, walk_left_in;
   logic               walk_fwd_ff, walk_fwd_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   sel_type            sel [CAPACITY];
   word_type           cell_q [CAPACITY];
   logic [CAP_W-1:0]   rd_idx;
   word_type           rd_word;

   logic               slot_free;
   logic               accept;
   logic               is_walk;
   logic               walk_start;
   logic [CMP_W-1:0]   cnt_x;
   logic [CMP_W-1:0]   idx_x;
   logic [CMP_W-1:0]   pos;
   logic               ins_req, del_req, ins_ok, del_ok;
   status_type         st;
   word_type           rv;

   // cell chain
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      word_type left_w, right_w;
      if (i == 0) begin : g_head
         assign left_w = req_data.value;
      end else begin : g_body
         assign left_w = cell_q[i-1];
      end
      if (i == CAPACITY - 1) begin : g_tail
         assign right_w = '0;
      end else begin : g_inner
         assign right_w = cell_q[i+1];
      end
      iarl_cell u_cell (
         .clock   (clock),
         .sel     (sel[i]),
         .left_d  (left_w),
         .right_d (right_w),
         .load_d  (req_data.value),
         .q       (cell_q[i])
      );
   end

   assign slot_free  = !rsp_valid_ff || rsp_ready;
   assign accept     = req_valid && req_ready;
   assign is_walk    = (req_data.func == FN_WALK_FWD) || (req_data.func == FN_WALK_BWD);
   assign walk_start = accept && is_walk && (count_ff != '0);
   assign cnt_x      = CMP_W'(count_ff);
   assign idx_x      = CMP_W'(req_data.index);
   assign rd_idx     = (fsm_ff == FSM_WALK) ? walk_idx_ff : CAP_W'(req_data.index);
   assign rd_word    = cell_q[rd_idx];

   // next state
   always_comb begin
      fsm_in = fsm_ff;
      unique case (fsm_ff)
         FSM_IDLE: begin
            if (walk_start) fsm_in = FSM_WALK;
         end
         FSM_WALK: begin
            if (slot_free && walk_left_ff == CNT_W'(1)) fsm_in = FSM_IDLE;
         end
         default: fsm_in = FSM_IDLE;
      endcase
   end

   // operation decode
   always_comb begin
      ins_req = 1'b0;
      del_req = 1'b0;
      ins_ok  = 1'b0;
      del_ok  = 1'b0;
      pos     = '0;
      st      = ST_OK;
      rv      = '0;
      unique case (req_data.func)
         FN_GET: begin
            if (idx_x < cnt_x) rv = rd_word;
            else st = ST_RANGE;
         end
         FN_INS_AT: begin
            ins_req = 1'b1;
            pos     = idx_x;
         end
         FN_INS_FIRST: begin
            ins_req = 1'b1;
         end
         FN_INS_LAST: begin
            ins_req = 1'b1;
            pos     = cnt_x;
         end
         FN_DEL_AT: begin
            del_req = 1'b1;
            pos     = idx_x;
         end
         FN_DEL_FIRST: begin
            del_req = 1'b1;
         end
         FN_DEL_LAST: begin
            del_req = 1'b1;
            pos     = cnt_x - CMP_W'(1);
         end
         FN_WALK_FWD, FN_WALK_BWD: begin
            if (count_ff == '0) st = ST_EMPTY;
         end
         default: ;
      endcase
      if (ins_req) begin
         if (pos > cnt_x) st = ST_RANGE;
         else if (cnt_x >= CMP_W'(CAPACITY)) st = ST_FULL;
         else ins_ok = 1'b1;
      end
      if (del_req) begin
         if (count_ff == '0) st = ST_EMPTY;
         else if (pos >= cnt_x) st = ST_RANGE;
         else del_ok = 1'b1;
      end
   end

   // outputs and register inputs
   always_comb begin
      req_ready    = (fsm_ff == FSM_IDLE) && slot_free;
      count_in     = count_ff;
      walk_idx_in  = walk_idx_ff;
      walk_left_in = walk_left_ff;
      walk_fwd_in  = walk_fwd_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      for (int i = 0; i < CAPACITY; i++) begin
         sel[i] = SEL_HOLD;
         if (accept && ins_ok) begin
            if (CMP_W'(i) > pos) sel[i] = SEL_LEFT;
            else if (CMP_W'(i) == pos) sel[i] = SEL_LOAD;
         end else if (accept && del_ok) begin
            if (CMP_W'(i) >= pos) sel[i] = SEL_RIGHT;
         end
      end
      unique case (fsm_ff)
         FSM_IDLE: begin
            if (accept && ins_ok) count_in = count_ff + CNT_W'(1);
            else if (accept && del_ok) count_in = count_ff - CNT_W'(1);
            if (walk_start) begin
               walk_fwd_in  = (req_data.func == FN_WALK_FWD);
               walk_idx_in  = (req_data.func == FN_WALK_FWD) ? '0
                              : CAP_W'(count_ff - CNT_W'(1));
               walk_left_in = count_ff;
            end else if (accept) begin
               rsp_in.read_value = rv;
               rsp_in.status     = st;
               rsp_in.count      = COUNT_W'(count_in);
               rsp_in.last       = 1'b1;
               rsp_valid_in      = 1'b1;
            end
         end
         FSM_WALK: begin
            if (slot_free) begin
               rsp_in.read_value = rd_word;
               rsp_in.status     = ST_OK;
               rsp_in.count      = COUNT_W'(count_ff);
               rsp_in.last       = (walk_left_ff == CNT_W'(1));
               rsp_valid_in      = 1'b1;
               walk_left_in      = walk_left_ff - CNT_W'(1);
               walk_idx_in       = walk_fwd_ff ? walk_idx_ff + CAP_W'(1)
                                               : walk_idx_ff - CAP_W'(1);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff       <= FSM_IDLE;
         count_ff     <= '0;
         walk_left_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fsm_ff       <= fsm_in;
         count_ff     <= count_in;
         walk_left_ff <= walk_left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      walk_idx_ff <= walk_idx_in;
      walk_fwd_ff <= walk_fwd_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("element count above capacity");

   a_walk_blocks: assert property (@(posedge clock) disable iff (reset)
      fsm_ff == FSM_WALK |-> !req_ready && walk_left_ff != '0)
      else $error("walk running with request side open or nothing left");

   a_walk_count_hold: assert property (@(posedge clock) disable iff (reset)
      fsm_ff == FSM_WALK |=> $stable(count_ff))
      else $error("count changed during walk");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      accept && ins_ok |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("accepted insert did not grow the list");

   a_walk_last: assert property (@(posedge clock) disable iff (reset)
      fsm_ff == FSM_WALK && slot_free && walk_left_ff == CNT_W'(1)
      |=> fsm_ff == FSM_IDLE && rsp_valid_ff && rsp_ff.last)
      else $error("walk ended without a last beat");
`endif

endmodule
